>>> src/snic_pkg.sv
// Package for the sorted neighbor intersection counter.
// Holds default sizes, operation codes and register indexes; no dependencies.
package snic_pkg;

   localparam int STORE_DEPTH_DEFAULT = 1024;
   localparam int ID_WIDTH_DEFAULT    = 32;

   // Width of the saturating match counter and of the result transfer.
   localparam int COUNT_W = 32;
   localparam int RSP_W   = ((COUNT_W + 1 + 7) / 8) * 8;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_PROBE  = 2'd1,
      OP_FINISH = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   localparam logic CSR_CENTER_VERTEX = 1'b0;
   localparam logic CSR_OTHER_VERTEX  = 1'b1;

endpackage

>>> src/snic_cell.sv
// One step cell of the binary search chain, with its own copy of the id store.
// Depends on snic_pkg for default sizes.
module snic_cell #(
   parameter int STORE_DEPTH = snic_pkg::STORE_DEPTH_DEFAULT,
   parameter int ID_WIDTH    = snic_pkg::ID_WIDTH_DEFAULT,
   localparam int IDX_W      = $clog2(STORE_DEPTH),
   localparam int LEN_W      = $clog2(STORE_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  logic [ID_WIDTH-1:0] wr_data,
   input  logic [LEN_W-1:0]    store_len,
   input  logic                in_valid,
   input  logic [ID_WIDTH-1:0] in_key,
   input  logic [LEN_W-1:0]    in_lo,
   input  logic [LEN_W-1:0]    in_hi,
   input  logic [LEN_W-1:0]    in_addr,
   output logic                out_valid,
   output logic [ID_WIDTH-1:0] out_key,
   output logic [LEN_W-1:0]    out_lo,
   output logic [LEN_W-1:0]    out_hi,
   output logic [LEN_W-1:0]    out_addr,
   output logic                out_hit
);
   import snic_pkg::*;

   logic [ID_WIDTH-1:0] bank_mem [STORE_DEPTH];

   logic                valid_ff;
   logic [ID_WIDTH-1:0] key_ff;
   logic [LEN_W-1:0]    lo_ff;
   logic [LEN_W-1:0]    hi_ff;
   logic [LEN_W-1:0]    mid_ff;
   logic [ID_WIDTH-1:0] rdata_ff;

   logic [LEN_W-1:0]    lo_in;
   logic [LEN_W-1:0]    hi_in;
   logic [LEN_W-1:0]    span;

   // Every cell sees every load, so all copies of the store stay identical.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= bank_mem[in_addr[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= in_key;
      lo_ff  <= in_lo;
      hi_ff  <= in_hi;
      mid_ff <= in_addr;
   end

   // Lower-bound step; once the window is empty the bounds pass unchanged.
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (lo_ff < hi_ff) begin
         if (rdata_ff < key_ff) begin
            lo_in = mid_ff + LEN_W'(1);
         end else begin
            hi_in = mid_ff;
         end
      end
   end

   // With an empty window the midpoint equals lo, which the last cell reads.
   assign span      = hi_in - lo_in;
   assign out_addr  = lo_in + (span >> 1);
   assign out_valid = valid_ff;
   assign out_key   = key_ff;
   assign out_lo    = lo_in;
   assign out_hi    = hi_in;
   assign out_hit   = valid_ff && (lo_ff < store_len) && (rdata_ff == key_ff);

endmodule

>>> src/sorted_neighbor_intersect_count.sv
// Top level of the sorted neighbor intersection counter.
// Depends on snic_pkg and snic_cell.
//
// This block counts how many probe ids of one vertex's neighbor list are found
// in a stored, ascending neighbor list of another vertex. Load transfers append
// ids below other_vertex_id to the store; such a load into a full store is
// dropped and sets the overflow flag. A probe counts when its id is below
// other_vertex_id, differs from both vertex ids, and a lower-bound binary
// search finds it in the store. A finish transfer returns the saturating count
// and the overflow flag and restarts the count; a clear transfer empties the
// store and clears the flag but keeps the count. A probe that reaches the
// search walks a chain of $clog2(STORE_DEPTH+1) search cells plus one compare
// cell, one cell per cycle; the count is updated from the compare cell's
// report, and the next transfer is taken only after the count is updated.
// Each cell keeps its own copy of the store so that every step has its own
// read port. A probe filtered out by the vertex id tests never enters the
// search chain.
// The result sits in an output register, so loads, probes and clears are
// taken while a result waits; only another finish waits for it to drain.
// Configuration writes are taken whenever csr_we is high, but the registers
// must only change while the block is idle.
module sorted_neighbor_intersect_count #(
   parameter int STORE_DEPTH = snic_pkg::STORE_DEPTH_DEFAULT,
   parameter int ID_WIDTH    = snic_pkg::ID_WIDTH_DEFAULT,
   localparam int REQ_W      = ((ID_WIDTH + 2 + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   // Input channel. tdata: opcode [1:0], item_id [ID_WIDTH+1:2], zero padding.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_W-1:0]         req_tdata,
   // Result channel. tdata: shared_edge_count [31:0], store_overflow [32],
   // zero padding.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [snic_pkg::RSP_W-1:0] rsp_tdata,
   // Configuration: index 0 center_vertex_id, index 1 other_vertex_id.
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [ID_WIDTH-1:0]      csr_wdata
);
   import snic_pkg::*;

   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int LEN_W = $clog2(STORE_DEPTH + 1);
   // One search cell per possible halving, then one compare cell.
   localparam int CELLS = LEN_W + 1;

   // Configuration registers.
   logic [ID_WIDTH-1:0] center_id_ff;
   logic [ID_WIDTH-1:0] other_id_ff;

   // Block state.
   logic [LEN_W-1:0]   store_len_ff;
   logic [COUNT_W-1:0] match_total_ff;
   logic               overflow_ff;
   logic               busy_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_ovf_ff;

   // Request decode.
   opcode_type          req_op;
   logic [ID_WIDTH-1:0] req_id;
   logic                req_xfer;
   logic                id_below_other;
   logic                launch;
   logic                store_write;

   // Links between cells; entry 0 is driven here, entry CELLS by the last cell.
   logic                chain_valid [CELLS+1];
   logic [ID_WIDTH-1:0] chain_key   [CELLS+1];
   logic [LEN_W-1:0]    chain_lo    [CELLS+1];
   logic [LEN_W-1:0]    chain_hi    [CELLS+1];
   logic [LEN_W-1:0]    chain_addr  [CELLS+1];
   logic                chain_hit   [CELLS];

   logic search_done;

   assign req_op         = opcode_type'(req_tdata[1:0]);
   assign req_id         = req_tdata[ID_WIDTH+1:2];
   assign id_below_other = req_id < other_id_ff;

   // Every transfer needs the search chain to be empty; a finish also needs
   // the output register free.
   assign req_tready = !busy_ff && ((req_op != OP_FINISH) || !rsp_valid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;

   assign launch = req_xfer && (req_op == OP_PROBE) && id_below_other &&
                   (req_id != center_id_ff);
   assign store_write = req_xfer && (req_op == OP_LOAD) && id_below_other &&
                        (store_len_ff < LEN_W'(STORE_DEPTH));

   // The search starts over the whole filled part of the store.
   assign chain_valid[0] = launch;
   assign chain_key[0]   = req_id;
   assign chain_lo[0]    = '0;
   assign chain_hi[0]    = store_len_ff;
   assign chain_addr[0]  = store_len_ff >> 1;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      snic_cell #(
         .STORE_DEPTH (STORE_DEPTH),
         .ID_WIDTH    (ID_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (store_write),
         .wr_addr   (store_len_ff[IDX_W-1:0]),
         .wr_data   (req_id),
         .store_len (store_len_ff),
         .in_valid  (chain_valid[i]),
         .in_key    (chain_key[i]),
         .in_lo     (chain_lo[i]),
         .in_hi     (chain_hi[i]),
         .in_addr   (chain_addr[i]),
         .out_valid (chain_valid[i+1]),
         .out_key   (chain_key[i+1]),
         .out_lo    (chain_lo[i+1]),
         .out_hi    (chain_hi[i+1]),
         .out_addr  (chain_addr[i+1]),
         .out_hit   (chain_hit[i])
      );
   end

   assign search_done = chain_valid[CELLS];

   always_ff @(posedge clock) begin
      if (reset) begin
         center_id_ff <= '0;
         other_id_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_VERTEX: begin
               center_id_ff <= csr_wdata;
            end
            CSR_OTHER_VERTEX: begin
               other_id_ff <= csr_wdata;
            end
            default: begin
               center_id_ff <= center_id_ff;
            end
         endcase
      end
   end

   // A probe owns the chain from launch until its compare cell reports.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (launch) begin
         busy_ff <= 1'b1;
      end else if (search_done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_len_ff   <= '0;
         match_total_ff <= '0;
         overflow_ff    <= 1'b0;
      end else begin
         if (search_done && chain_hit[CELLS-1] && (match_total_ff != COUNT_MAX)) begin
            match_total_ff <= match_total_ff + COUNT_W'(1);
         end
         if (req_xfer) begin
            case (req_op)
               OP_LOAD: begin
                  if (store_write) begin
                     store_len_ff <= store_len_ff + LEN_W'(1);
                  end else if (id_below_other) begin
                     overflow_ff <= 1'b1;
                  end
               end
               OP_PROBE: begin
                  store_len_ff <= store_len_ff;
               end
               OP_FINISH: begin
                  match_total_ff <= '0;
               end
               OP_CLEAR: begin
                  store_len_ff <= '0;
                  overflow_ff  <= 1'b0;
               end
               default: begin
                  store_len_ff <= store_len_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer && (req_op == OP_FINISH)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && (req_op == OP_FINISH)) begin
         rsp_count_ff <= match_total_ff;
         rsp_ovf_ff   <= overflow_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - COUNT_W - 1){1'b0}}, rsp_ovf_ff, rsp_count_ff};

endmodule

>>> src/snic_checker.sv
// Port-level checker for the sorted neighbor intersection counter, with its bind.
// Depends on snic_pkg and the top level sorted_neighbor_intersect_count.
module snic_checker #(
   parameter int ID_WIDTH = snic_pkg::ID_WIDTH_DEFAULT,
   localparam int REQ_W   = ((ID_WIDTH + 2 + 7) / 8) * 8
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [REQ_W-1:0]           req_tdata,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [snic_pkg::RSP_W-1:0] rsp_tdata,
   input logic                       csr_we,
   input logic                       csr_index,
   input logic [ID_WIDTH-1:0]        csr_wdata
);
   import snic_pkg::*;

   logic req_xfer;
   logic finish_xfer;
   logic clear_xfer;
   logic cfg_seen;

   assign req_xfer    = req_tvalid && req_tready;
   assign finish_xfer = req_xfer && (req_tdata[1:0] == OP_FINISH);
   assign clear_xfer  = req_xfer && (req_tdata[1:0] == OP_CLEAR);
   assign cfg_seen    = csr_we && (csr_index == CSR_OTHER_VERTEX) && (csr_wdata != '0);

   // A waiting result holds still until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Every accepted finish produces a result in the next cycle.
   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      finish_xfer |=> rsp_tvalid)
      else $error("finish without result");

   // A result only appears because of a finish.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(finish_xfer))
      else $error("result without finish");

   // Two finishes in a row: the second count starts from zero.
   a_count_restart: assert property (@(posedge clock) disable iff (reset || cfg_seen)
      finish_xfer ##1 finish_xfer |=> (rsp_tdata[COUNT_W-1:0] == '0))
      else $error("count not restarted by finish");

   // A clear followed directly by a finish reports no overflow.
   a_clear_overflow: assert property (@(posedge clock) disable iff (reset)
      clear_xfer ##1 finish_xfer |=> !rsp_tdata[COUNT_W])
      else $error("overflow survived clear");

endmodule

bind sorted_neighbor_intersect_count snic_checker #(.ID_WIDTH(ID_WIDTH)) u_snic_checker (.*);

>>> dv/tb.sv
// Self-checking testbench for sorted_neighbor_intersect_count.
// Needs snic_pkg and the block's RTL. Expected counts come from an in-bench
// predictor that sees every accepted transfer and every register write.
module tb;
   import snic_pkg::*;

   localparam int ID_W  = ID_WIDTH_DEFAULT;
   localparam int DEPTH = STORE_DEPTH_DEFAULT;
   localparam int REQ_W = ((ID_W + 2 + 7) / 8) * 8;
   localparam logic [ID_W-1:0] ID_MAX = '1;

   localparam int IDLE_PCT        = 15;    // idle cycles per hundred, each side
   localparam int RANDOM_ITEMS    = 1850;
   localparam int HOLD_OFF_CYCLES = 400;   // one long receiver stall
   // Long enough for a probe still in flight to finish its search.
   localparam int SETTLE_CYCLES   = 24;
   // Longest quiet stretch in a correct run is the receiver hold-off.
   localparam int WATCHDOG_LIMIT  = 5000;

   typedef struct packed {
      logic [COUNT_W-1:0] shared_edges;
      logic               overflow;
   } finish_result_type;

   // Tracks the store, the running match total and the overflow flag, and
   // holds the results that finish transfers are still owed.
   class intersect_scoreboard_type;
      logic [ID_W-1:0]    center_id;
      logic [ID_W-1:0]    other_id;
      logic [ID_W-1:0]    id_store[DEPTH];
      int unsigned        store_len;
      logic [COUNT_W-1:0] match_total;
      logic               overflow_seen;
      finish_result_type  owed_results[$];
      int unsigned        errors;

      function new();
         center_id     = '0;
         other_id      = '0;
         store_len     = 0;
         match_total   = '0;
         overflow_seen = 1'b0;
         errors        = 0;
      endfunction

      function void write_reg(logic index, logic [ID_W-1:0] value);
         if (index == CSR_CENTER_VERTEX) begin
            center_id = value;
         end else begin
            other_id = value;
         end
      endfunction

      // Lower-bound search over the filled part of the store; its answer is
      // taken as is even when the loads were not ascending.
      function bit store_holds(logic [ID_W-1:0] key);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         lo = 0;
         hi = store_len;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (id_store[mid] < key) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         if (lo >= store_len) return 1'b0;
         return id_store[lo] == key;
      endfunction

      function void note_transfer(opcode_type op, logic [ID_W-1:0] id);
         finish_result_type owed;
         case (op)
            OP_LOAD: begin
               if (id < other_id) begin
                  if (store_len < DEPTH) begin
                     id_store[store_len] = id;
                     store_len++;
                  end else begin
                     overflow_seen = 1'b1;
                  end
               end
            end
            OP_PROBE: begin
               if (id < other_id && id != center_id && store_holds(id) &&
                   match_total != COUNT_MAX)
                  match_total++;
            end
            OP_FINISH: begin
               owed = '{shared_edges: match_total, overflow: overflow_seen};
               owed_results = {owed_results, owed};
               match_total = '0;
            end
            default: begin
               store_len     = 0;
               overflow_seen = 1'b0;
            end
         endcase
      endfunction

      function void check_result(logic [COUNT_W-1:0] shared_edges, logic overflow);
         finish_result_type want;
         if (owed_results.size() == 0) begin
            $display("%0t: result with none owed: count %0d overflow %0b",
                     $time, shared_edges, overflow);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         if (shared_edges !== want.shared_edges) begin
            $display("%0t: shared_edge_count expected %0d actual %0d",
                     $time, want.shared_edges, shared_edges);
            errors++;
         end
         if (overflow !== want.overflow) begin
            $display("%0t: store_overflow expected %0b actual %0b",
                     $time, want.overflow, overflow);
            errors++;
         end
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;   // opcode [1:0], item_id [33:2], zero padding
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;         // shared_edge_count [31:0], store_overflow [32]
   logic               csr_we     = 1'b0;
   logic               csr_index  = CSR_CENTER_VERTEX;
   logic [ID_W-1:0]    csr_wdata  = '0;

   intersect_scoreboard_type sb = new();

   // Stimulus state shared by the driving tasks and the receiver process.
   bit                 calm         = 1'b0;  // no idling on either side
   bit                 hold_off_req = 1'b0;  // asks the receiver for a long stall
   int unsigned        items_sent   = 0;
   int unsigned        quiet_cycles = 0;
   logic [ID_W-1:0]    cur_center   = '0;
   logic [ID_W-1:0]    cur_other    = '0;
   logic [ID_W-1:0]    list_ids[$];          // ids loaded in the current phase

   always #10 clock = ~clock;

   sorted_neighbor_intersect_count u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Monitor: every accepted transfer and register write feeds the predictor
   // at the edge where it happens. The watchdog counts edges with no activity.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (req_tvalid && req_tready)
            sb.note_transfer(opcode_type'(req_tdata[1:0]), req_tdata[ID_W+1:2]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[COUNT_W-1:0], rsp_tdata[COUNT_W]);
         if (csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("sorted_neighbor_intersect_count test failed");
         $finish;
      end
   end

   // Receiver: random back-pressure, none while calm. On request it holds
   // rsp_tready low for a long stretch, so a finish result sits in the output
   // register and the next finish stalls the input channel.
   initial begin
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Offers one item, with random idle cycles ahead of it, and returns at the
   // edge where the transfer happens. tvalid stays high for a following item.
   task automatic send_item(input opcode_type op, input logic [ID_W-1:0] id);
      if (!calm) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-ID_W-2){1'b0}}, id, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_csr(input logic index, input logic [ID_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Stops offering, waits for every owed result, then lets a trailing probe
   // finish its search so that the block is idle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_vertices(input logic [ID_W-1:0] center, input logic [ID_W-1:0] other);
      write_csr(CSR_CENTER_VERTEX, center);
      write_csr(CSR_OTHER_VERTEX, other);
      cur_center = center;
      cur_other  = other;
   endtask

   // Ascending ids spread below the other vertex id. Once the range runs out,
   // random ids are taken instead, which acts as unsorted or dropped loads.
   function automatic void build_list(input int n, input logic [ID_W-1:0] other);
      longint unsigned next_id;
      longint unsigned stride;
      list_ids.delete();
      stride = longint'(other) / (n + 1);
      if (stride == 0) stride = 1;
      if (stride > 64'h7FFF_FFFF) stride = 64'h7FFF_FFFF;
      next_id = $urandom_range(0, stride - 1);
      for (int i = 0; i < n; i++) begin
         if (next_id < longint'(other)) begin
            list_ids = {list_ids, next_id[ID_W-1:0]};
         end else begin
            list_ids = {list_ids, ID_W'($urandom)};
         end
         next_id += $urandom_range(1, stride);
      end
   endfunction

   // Probe ids: mostly hits in the current list, with neighbors of hits, both
   // vertex ids, repeats, ids at or above the bound, and random ids.
   function automatic logic [ID_W-1:0] pick_probe(input logic [ID_W-1:0] prev);
      int unsigned k;
      k = $urandom_range(99);
      if (list_ids.size() != 0 && k < 50)
         return list_ids[$urandom_range(list_ids.size() - 1)];
      if (list_ids.size() != 0 && k < 60)
         return list_ids[$urandom_range(list_ids.size() - 1)] +
                ($urandom_range(1) ? 32'd1 : ID_MAX);
      if (k < 68) return cur_center;
      if (k < 76) return cur_other;
      if (k < 84) return prev;
      if (k < 92) return cur_other + $urandom_range(1, 1000);
      return $urandom;
   endfunction

   // One random phase: new vertex ids, usually a clear, a load list with some
   // noise, probes with the odd extra finish or clear, and a closing finish.
   // Under pressure the receiver stalls while a finish follows every probe.
   task automatic run_phase(input bit pressure);
      int              n_loads;
      int              n_probes;
      logic [ID_W-1:0] other;
      logic [ID_W-1:0] center;
      logic [ID_W-1:0] probe_id;
      case ($urandom_range(5))
         0:       other = ID_MAX;
         1, 2:    other = $urandom;
         3:       other = $urandom_range(1, 300);
         4:       other = '0;
         default: other = $urandom_range(1, 65535);
      endcase
      n_loads = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 40);
      build_list(n_loads, other);
      case ($urandom_range(5))
         0:       center = '0;
         1:       center = ID_MAX;
         2:       center = other;
         default: center = (list_ids.size() != 0) ?
                           list_ids[$urandom_range(list_ids.size() - 1)] : $urandom;
      endcase
      wait_idle();
      set_vertices(center, other);
      if (pressure) hold_off_req = 1'b1;
      // Skipping the clear now and then keeps an older store under new ids.
      if ($urandom_range(4) != 0) send_item(OP_CLEAR, $urandom);
      foreach (list_ids[i]) begin
         if ($urandom_range(99) < 8) send_item(OP_LOAD, $urandom);
         send_item(OP_LOAD, list_ids[i]);
      end
      n_probes = pressure ? 20 : $urandom_range(1, 30);
      probe_id = '0;
      for (int i = 0; i < n_probes; i++) begin
         probe_id = pick_probe(probe_id);
         send_item(OP_PROBE, probe_id);
         if (pressure || $urandom_range(99) < 5) begin
            send_item(OP_FINISH, $urandom);
         end else if ($urandom_range(99) < 3) begin
            send_item(OP_CLEAR, $urandom);
         end
      end
      send_item(OP_FINISH, $urandom);
   endtask

   initial begin
      int unsigned     items_goal;
      int              phase;
      logic [ID_W-1:0] probe_id;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. With both vertex ids at zero every load is dropped.
      send_item(OP_LOAD, 32'd5);
      send_item(OP_PROBE, 32'd5);
      send_item(OP_FINISH, '0);
      wait_idle();

      // Full id range: the id at the bound is dropped, the center id and ids
      // at the bound never match, and a repeated probe counts twice.
      set_vertices(32'd5, ID_MAX);
      send_item(OP_CLEAR, '0);
      send_item(OP_LOAD, 32'd0);
      send_item(OP_LOAD, 32'd5);
      send_item(OP_LOAD, 32'd7);
      send_item(OP_LOAD, ID_MAX - 1);
      send_item(OP_LOAD, ID_MAX);
      send_item(OP_PROBE, 32'd0);
      send_item(OP_PROBE, 32'd5);
      send_item(OP_PROBE, 32'd7);
      send_item(OP_PROBE, 32'd7);
      send_item(OP_PROBE, ID_MAX - 1);
      send_item(OP_PROBE, ID_MAX);
      send_item(OP_PROBE, 32'd3);
      send_item(OP_FINISH, ID_MAX);
      // An out-of-order load that the binary search does not find.
      send_item(OP_LOAD, 32'd2);
      send_item(OP_PROBE, 32'd2);
      send_item(OP_PROBE, 32'd6);
      send_item(OP_FINISH, $urandom);
      // After a clear nothing is found.
      send_item(OP_CLEAR, $urandom);
      send_item(OP_PROBE, 32'd7);
      send_item(OP_FINISH, $urandom);

      items_goal = items_sent + RANDOM_ITEMS;

      // Fill the store to its depth with no idling. A load at the bound into
      // a full store is dropped without the flag; loads below it set the flag,
      // which survives a finish and goes away with a clear.
      wait_idle();
      calm = 1'b1;
      build_list(DEPTH, ID_MAX);
      set_vertices($urandom, ID_MAX);
      send_item(OP_CLEAR, $urandom);
      foreach (list_ids[i]) send_item(OP_LOAD, list_ids[i]);
      send_item(OP_LOAD, ID_MAX);
      probe_id = '0;
      for (int i = 0; i < 20; i++) begin
         probe_id = pick_probe(probe_id);
         send_item(OP_PROBE, probe_id);
      end
      send_item(OP_FINISH, $urandom);
      for (int i = 0; i < 3; i++) send_item(OP_LOAD, $urandom_range(0, ID_MAX - 1));
      for (int i = 0; i < 20; i++) begin
         probe_id = pick_probe(probe_id);
         send_item(OP_PROBE, probe_id);
      end
      send_item(OP_FINISH, $urandom);
      send_item(OP_PROBE, list_ids[0]);
      send_item(OP_FINISH, $urandom);
      send_item(OP_CLEAR, $urandom);
      send_item(OP_FINISH, $urandom);
      calm = 1'b0;

      // Random phases; one under receiver hold-off and a calm stretch.
      phase = 0;
      while (items_sent < items_goal) begin
         calm = (phase >= 4 && phase < 8);
         run_phase(phase == 2);
         phase++;
      end
      calm = 1'b0;

      wait_idle();
      if (sb.errors == 0) begin
         $display("sorted_neighbor_intersect_count test passed");
      end else begin
         $display("sorted_neighbor_intersect_count test failed");
      end
      $finish;
   end

endmodule
